[sv/rx_slot_table_with_timeout_macros.svh]
// Assertion macros for the receive slot table checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef RX_SLOT_TABLE_WITH_TIMEOUT_MACROS_SVH
`define RX_SLOT_TABLE_WITH_TIMEOUT_MACROS_SVH

// Same-cycle implication.
`define RXST_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RXST_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rxst_pkg.sv]
// Shared types and constants for the receive slot table.
// No dependencies; used by the interfaces, controller, datapath and checker.
package rxst_pkg;

	localparam int SLOTS_DEF          = 16;
	localparam int MAX_PACKET_LEN_DEF = 2048;
	localparam int LEN_STORE_MAX      = 4095;
	localparam logic [31:0] TIMEOUT_RESET = 32'd3000;

	localparam int OPCODE_W    = 2;
	localparam int OWNER_W     = 8;
	localparam int SLOT_W      = 4;
	localparam int IN_LEN_W    = 16;
	localparam int TICK_W      = 32;
	localparam int STATUS_W    = 3;
	localparam int LENW        = 12;
	localparam int COUNT_W     = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_STORE = 2'd0,
		OP_GET   = 2'd1,
		OP_FREE  = 2'd2
	} rxst_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_FOCUS = 3'd1,
		ST_NO_SLOT  = 3'd2,
		ST_BAD_ARG  = 3'd3,
		ST_MISMATCH = 3'd4
	} rxst_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCUS_OWNER   = 1'd0,
		REG_TIMEOUT_TICKS = 1'd1
	} rxst_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_GET,
		S_RESP
	} rxst_state_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic scan;
		logic get_chk;
		logic load_out;
	} rxst_cmd_t;

	typedef struct packed {
		logic early_done;
		logic is_get;
		logic scan_done;
		logic out_free;
	} rxst_stat_t;

endpackage

[sv/rxst_in_if.sv]
// Request channel of the receive slot table.
// Depends on rxst_pkg for field widths.
interface rxst_in_if;
	import rxst_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [OWNER_W-1:0]  owner;
	logic [SLOT_W-1:0]   slot_index;
	logic [IN_LEN_W-1:0] length;
	logic [TICK_W-1:0]   now_tick;

	modport source (output valid, opcode, owner, slot_index, length, now_tick, input ready);
	modport sink (input valid, opcode, owner, slot_index, length, now_tick, output ready);
endinterface

[sv/rxst_out_if.sv]
// Response channel of the receive slot table.
// Depends on rxst_pkg for field widths.
interface rxst_out_if;
	import rxst_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   result_slot;
	logic [LENW-1:0]     result_length;
	logic [COUNT_W-1:0]  freed_count;
	logic [COUNT_W-1:0]  live_count;

	modport source (output valid, status, result_slot, result_length, freed_count, live_count,
		input ready);
	modport sink (input valid, status, result_slot, result_length, freed_count, live_count,
		output ready);
endinterface

[sv/rxst_cfg_if.sv]
// Register write channel of the receive slot table.
// Depends on rxst_pkg for index and data widths.
interface rxst_cfg_if;
	import rxst_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/rxst_ctrl.sv]
// Sequencer of the receive slot table: accept, decode, scan or get unless decode settles it, respond.
// Depends on rxst_pkg; drives rxst_datapath through rxst_cmd_t.
module rxst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rxst_pkg::rxst_stat_t stat,
	output rxst_pkg::rxst_cmd_t  cmd
);
	import rxst_pkg::*;

	rxst_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.early_done) begin
					state_d = S_RESP;
				end else if (stat.is_get) begin
					state_d = S_GET;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_RESP;
				end
			end
			S_GET: begin
				cmd.get_chk = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/rxst_datapath.sv]
// Slot memory, occupancy bits, scan pipeline, config registers and output register.
// Depends on rxst_pkg and the channel interfaces; sequenced by rxst_ctrl.
module rxst_datapath #(
	parameter int SLOTS          = rxst_pkg::SLOTS_DEF,
	parameter int MAX_PACKET_LEN = rxst_pkg::MAX_PACKET_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rxst_pkg::rxst_cmd_t             cmd,
	output rxst_pkg::rxst_stat_t            stat,
	input  logic [rxst_pkg::OPCODE_W-1:0]   in_opcode,
	input  logic [rxst_pkg::OWNER_W-1:0]    in_owner,
	input  logic [rxst_pkg::SLOT_W-1:0]     in_slot_index,
	input  logic [rxst_pkg::IN_LEN_W-1:0]   in_length,
	input  logic [rxst_pkg::TICK_W-1:0]     in_now_tick,
	rxst_out_if.source                      out_ch,
	rxst_cfg_if.sink                        cfg_ch
);
	import rxst_pkg::*;

	localparam int IDXW    = $clog2(SLOTS);
	localparam int CNTW    = $clog2(SLOTS + 1);
	localparam int LEN_CAP = (MAX_PACKET_LEN > LEN_STORE_MAX) ? LEN_STORE_MAX : MAX_PACKET_LEN;

	// slot table
	logic [OWNER_W-1:0] owner_mem [SLOTS];
	logic [TICK_W-1:0]  stamp_mem [SLOTS];
	logic [LENW-1:0]    len_mem   [SLOTS];
	logic [SLOTS-1:0]   occ_q;
	logic [CNTW-1:0]    count_q;

	// config
	logic [OWNER_W-1:0] focus_q;
	logic [TICK_W-1:0]  timeout_q;

	// captured request
	logic [OPCODE_W-1:0] op_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [IN_LEN_W-1:0] len_q;
	logic [TICK_W-1:0]   now_q;

	// scan pipeline
	logic [CNTW-1:0]    cnt_q;
	logic               chk_vld_s1;
	logic [IDXW-1:0]    chk_addr_s1;
	logic               rd_occ_s1;
	logic [OWNER_W-1:0] rd_owner_s1;
	logic [TICK_W-1:0]  rd_stamp_s1;
	logic [LENW-1:0]    rd_len_s1;

	// result
	rxst_status_t    res_status_q;
	logic [IDXW-1:0] res_slot_q;
	logic [LENW-1:0] res_len_q;
	logic [CNTW-1:0] freed_q;

	logic         out_valid_q;
	rxst_status_t out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [LENW-1:0]    out_len_q;
	logic [COUNT_W-1:0] out_freed_q;
	logic [COUNT_W-1:0] out_live_q;

	rxst_status_t    early_status;
	logic            early_done;
	logic            is_get;
	logic            cnt_lt;
	logic            rd_en;
	logic [IDXW-1:0] rd_addr;
	logic [IDXW-1:0] idx_ix;
	logic [TICK_W-1:0] age;
	logic            store_hit;
	logic            own_match;
	logic            is_last;
	logic            do_store;
	logic            do_free;
	logic            do_get;
	logic [LENW-1:0] len_clamp;
	logic [LENW-1:0] get_len;

	// decide what can be answered without touching the table
	always_comb begin
		early_done   = 1'b1;
		early_status = ST_BAD_ARG;
		is_get       = 1'b0;
		case (op_q)
			OP_STORE: begin
				if (len_q == '0) begin
					early_status = ST_BAD_ARG;
				end else if (focus_q == '0) begin
					early_status = ST_NO_FOCUS;
				end else begin
					early_done   = 1'b0;
					early_status = ST_NO_SLOT;
				end
			end
			OP_GET: begin
				if (owner_q == '0 || len_q == '0 || 32'(idx_q) >= 32'(SLOTS)) begin
					early_status = ST_BAD_ARG;
				end else begin
					early_done   = 1'b0;
					early_status = ST_MISMATCH;
					is_get       = 1'b1;
				end
			end
			OP_FREE: begin
				if (owner_q != '0) begin
					early_done   = 1'b0;
					early_status = ST_OK;
				end
			end
			default: begin
				early_status = ST_BAD_ARG;
			end
		endcase
	end

	assign idx_ix  = IDXW'(idx_q);
	assign cnt_lt  = cnt_q < CNTW'(SLOTS);
	assign rd_en   = (cmd.decode && is_get) || (cmd.scan && cnt_lt);
	assign rd_addr = cmd.decode ? idx_ix : cnt_q[IDXW-1:0];

	assign age       = now_q - rd_stamp_s1;
	assign store_hit = !rd_occ_s1 || (age > timeout_q);
	assign own_match = rd_occ_s1 && (rd_owner_s1 == owner_q);
	assign is_last   = chk_addr_s1 == IDXW'(SLOTS - 1);

	assign do_store = cmd.scan && chk_vld_s1 && (op_q == OP_STORE) && store_hit;
	assign do_free  = cmd.scan && chk_vld_s1 && (op_q == OP_FREE) && own_match;
	assign do_get   = cmd.get_chk && own_match;

	assign len_clamp = (len_q > IN_LEN_W'(LEN_CAP)) ? LENW'(LEN_CAP) : len_q[LENW-1:0];
	assign get_len   = (len_q > IN_LEN_W'(rd_len_s1)) ? rd_len_s1 : len_q[LENW-1:0];

	assign stat.early_done = early_done;
	assign stat.is_get     = is_get;
	assign stat.scan_done  = chk_vld_s1 && (is_last || ((op_q == OP_STORE) && store_hit));
	assign stat.out_free   = !out_valid_q || out_ch.ready;

	// slot memory: one write port at the check stage, one registered read port
	always_ff @(posedge clk) begin
		if (do_store) begin
			owner_mem[chk_addr_s1] <= focus_q;
			stamp_mem[chk_addr_s1] <= now_q;
			len_mem[chk_addr_s1]   <= len_clamp;
		end
		if (rd_en) begin
			rd_owner_s1 <= owner_mem[rd_addr];
			rd_stamp_s1 <= stamp_mem[rd_addr];
			rd_len_s1   <= len_mem[rd_addr];
			rd_occ_s1   <= occ_q[rd_addr];
			chk_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_opcode;
			owner_q <= in_owner;
			idx_q   <= in_slot_index;
			len_q   <= in_length;
			now_q   <= in_now_tick;
		end
		if (cmd.decode) begin
			res_status_q <= early_status;
			res_slot_q   <= '0;
			res_len_q    <= '0;
			freed_q      <= '0;
		end else if (do_store) begin
			res_status_q <= ST_OK;
			res_slot_q   <= chk_addr_s1;
			res_len_q    <= len_clamp;
		end else if (do_get) begin
			res_status_q <= ST_OK;
			res_slot_q   <= chk_addr_s1;
			res_len_q    <= get_len;
		end else if (do_free) begin
			freed_q <= freed_q + CNTW'(1);
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= SLOT_W'(res_slot_q);
			out_len_q    <= res_len_q;
			out_freed_q  <= COUNT_W'(freed_q);
			out_live_q   <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			count_q     <= '0;
			cnt_q       <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_store) begin
				occ_q[chk_addr_s1] <= 1'b1;
				if (!rd_occ_s1) begin
					count_q <= count_q + CNTW'(1);
				end
			end else if (do_free || do_get) begin
				occ_q[chk_addr_s1] <= 1'b0;
				count_q            <= count_q - CNTW'(1);
			end
			if (cmd.decode) begin
				cnt_q      <= '0;
				chk_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				chk_vld_s1 <= cnt_lt;
				if (cnt_lt) begin
					cnt_q <= cnt_q + CNTW'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_q   <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_FOCUS_OWNER:   focus_q   <= cfg_ch.data[OWNER_W-1:0];
				REG_TIMEOUT_TICKS: timeout_q <= cfg_ch.data[TICK_W-1:0];
				default: begin
					focus_q <= focus_q;
				end
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.result_slot   = out_slot_q;
	assign out_ch.result_length = out_len_q;
	assign out_ch.freed_count   = out_freed_q;
	assign out_ch.live_count    = out_live_q;

endmodule

[sv/rx_slot_table_with_timeout.sv]
// Receive slot table with age timeout: store claims the lowest free or aged slot, get
// checks the owner and releases one slot, free releases every slot of an owner. One
// request is worked at a time and one response beat is produced per request. The slot
// table has one write and one registered read port and is walked one slot per cycle: a
// rejected request goes from decode to the response, a get checks its one slot, a store
// scans until it claims a slot and a free scans all slots. The next request is taken
// while the last response still waits on the output register. Occupancy lives in
// per-slot flip-flops cleared by reset, so the block is ready right after reset with no
// clearing pass. The user must change registers only while idle; the block does not enforce it.
module rx_slot_table_with_timeout #(
	parameter int SLOTS          = rxst_pkg::SLOTS_DEF,
	parameter int MAX_PACKET_LEN = rxst_pkg::MAX_PACKET_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rxst_in_if.sink     in_ch,
	rxst_out_if.source  out_ch,
	rxst_cfg_if.sink    cfg_ch
);
	import rxst_pkg::*;

	rxst_cmd_t  cmd;
	rxst_stat_t stat;

	rxst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rxst_datapath #(
		.SLOTS          (SLOTS),
		.MAX_PACKET_LEN (MAX_PACKET_LEN)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_opcode     (in_ch.opcode),
		.in_owner      (in_ch.owner),
		.in_slot_index (in_ch.slot_index),
		.in_length     (in_ch.length),
		.in_now_tick   (in_ch.now_tick),
		.out_ch        (out_ch),
		.cfg_ch        (cfg_ch)
	);

endmodule

[sv/rxst_checker.sv]
// Port-level checks on the response channel of the receive slot table.
// Depends on rxst_pkg and the assertion macro header; bound to the top level below.
`include "rx_slot_table_with_timeout_macros.svh"

module rxst_checker #(
	parameter int SLOTS          = rxst_pkg::SLOTS_DEF,
	parameter int MAX_PACKET_LEN = rxst_pkg::MAX_PACKET_LEN_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rxst_pkg::STATUS_W-1:0] out_status,
	input logic [rxst_pkg::SLOT_W-1:0]   out_result_slot,
	input logic [rxst_pkg::LENW-1:0]     out_result_length,
	input logic [rxst_pkg::COUNT_W-1:0]  out_freed_count,
	input logic [rxst_pkg::COUNT_W-1:0]  out_live_count
);
	import rxst_pkg::*;

	localparam int LEN_CAP = (MAX_PACKET_LEN > LEN_STORE_MAX) ? LEN_STORE_MAX : MAX_PACKET_LEN;
	localparam logic WIDE_TABLE = SLOTS > 31;

	`RXST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_result_length), "response dropped or changed while stalled")
	`RXST_ASSERT_IMP(a_status_code, out_valid, out_status <= ST_MISMATCH, "undefined status code")
	`RXST_ASSERT_IMP(a_fail_fields, out_valid && out_status != ST_OK, out_result_slot == '0 && out_result_length == '0 && out_freed_count == '0, "failed request carries data")
	`RXST_ASSERT_IMP(a_len_cap, out_valid, 32'(out_result_length) <= 32'(LEN_CAP), "length above clamp")
	`RXST_ASSERT_IMP(a_live_bound, out_valid, WIDE_TABLE || 32'(out_live_count) <= 32'(SLOTS), "live count above table size")

endmodule

bind rx_slot_table_with_timeout rxst_checker #(
	.SLOTS          (SLOTS),
	.MAX_PACKET_LEN (MAX_PACKET_LEN)
) u_rxst_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_status        (out_ch.status),
	.out_result_slot   (out_ch.result_slot),
	.out_result_length (out_ch.result_length),
	.out_freed_count   (out_ch.freed_count),
	.out_live_count    (out_ch.live_count)
);

[dv/tb_rx_slot_table_with_timeout.sv]
`timescale 1ns / 100ps
// Self-checking bench for rx_slot_table_with_timeout: store, get and free requests
// with their replies predicted by a slot ledger. Depends on rxst_pkg and the
// rxst_in_if, rxst_out_if and rxst_cfg_if interfaces.
module tb_rx_slot_table_with_timeout;
	import rxst_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [OWNER_W-1:0]  owner;
		logic [SLOT_W-1:0]   slot;
		logic [IN_LEN_W-1:0] length;
		logic [TICK_W-1:0]   tick;
	} request_t;

	typedef struct packed {
		rxst_status_t        status;
		logic [SLOT_W-1:0]   slot;
		logic [LENW-1:0]     length;
		logic [COUNT_W-1:0]  freed;
		logic [COUNT_W-1:0]  live;
	} reply_t;

	// Slot ledger: mirrors the table and queues the reply each request must produce.
	class slot_ledger;
		localparam int STORE_CAP = (MAX_PACKET_LEN_DEF > LEN_STORE_MAX) ?
			LEN_STORE_MAX : MAX_PACKET_LEN_DEF;

		logic [OWNER_W-1:0] owner_of [SLOTS_DEF];
		logic [TICK_W-1:0]  stamp_of [SLOTS_DEF];
		logic [LENW-1:0]    len_of [SLOTS_DEF];
		int                 live;
		logic [OWNER_W-1:0] focus;
		logic [TICK_W-1:0]  timeout;
		reply_t             replies_due[$];
		int errors, replies_seen, stores_placed, reclaims, full_refusals, gets_done;
		int owner_releases;

		function new();
			int i;
			for (i = 0; i < SLOTS_DEF; i++) begin
				owner_of[i] = '0;
				stamp_of[i] = '0;
				len_of[i] = '0;
			end
			live = 0;
			focus = '0;
			timeout = TIMEOUT_RESET;
		endfunction

		task note_error(string msg);
			errors++;
			$display("mismatch @%0t: %s", $time, msg);
		endtask

		function void set_reg(rxst_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FOCUS_OWNER:   focus = data[OWNER_W-1:0];
				REG_TIMEOUT_TICKS: timeout = data;
				default: ;
			endcase
		endfunction

		function void release_slot(int i);
			owner_of[i] = '0;
			stamp_of[i] = '0;
			len_of[i] = '0;
			if (live > 0)
				live--;
		endfunction

		function void take_request(request_t r);
			reply_t x;
			int i, freed;
			logic [TICK_W-1:0] age;
			logic [IN_LEN_W-1:0] len;
			x.status = ST_BAD_ARG;
			x.slot = '0;
			x.length = '0;
			x.freed = '0;
			freed = 0;
			case (r.opcode)
				OP_STORE: begin
					if (r.length == 0)
						x.status = ST_BAD_ARG;
					else if (focus == 0)
						x.status = ST_NO_FOCUS;
					else begin
						len = (r.length > STORE_CAP) ? IN_LEN_W'(STORE_CAP) : r.length;
						x.status = ST_NO_SLOT;
						// claim the lowest slot that is free or strictly older than the timeout
						for (i = 0; i < SLOTS_DEF && x.status == ST_NO_SLOT; i++) begin
							age = r.tick - stamp_of[i];
							if (owner_of[i] == 0 || age > timeout) begin
								if (owner_of[i] == 0)
									live++;
								else
									reclaims++;
								owner_of[i] = focus;
								stamp_of[i] = r.tick;
								len_of[i] = len[LENW-1:0];
								x.status = ST_OK;
								x.slot = SLOT_W'(i);
								x.length = len[LENW-1:0];
								stores_placed++;
							end
						end
						if (x.status == ST_NO_SLOT)
							full_refusals++;
					end
				end
				OP_GET: begin
					if (r.owner == 0 || r.length == 0 || r.slot >= SLOTS_DEF)
						x.status = ST_BAD_ARG;
					else if (owner_of[r.slot] != r.owner)
						x.status = ST_MISMATCH;
					else begin
						x.length = (r.length > len_of[r.slot]) ? len_of[r.slot] :
							r.length[LENW-1:0];
						x.slot = r.slot;
						x.status = ST_OK;
						release_slot(r.slot);
						gets_done++;
					end
				end
				OP_FREE: begin
					if (r.owner != 0) begin
						for (i = 0; i < SLOTS_DEF; i++) begin
							if (owner_of[i] == r.owner) begin
								release_slot(i);
								freed++;
							end
						end
						x.status = ST_OK;
						x.freed = COUNT_W'(freed);
						owner_releases += freed;
					end
				end
				default: ;
			endcase
			x.live = COUNT_W'(live);
			replies_due.push_back(x);
		endfunction

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				note_error($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task match_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				note_error($sformatf("reply beat with nothing pending, status %0d", got.status));
				return;
			end
			want = replies_due.pop_front();
			replies_seen++;
			compare_field("status", 32'(got.status), 32'(want.status));
			compare_field("result_slot", 32'(got.slot), 32'(want.slot));
			compare_field("result_length", 32'(got.length), 32'(want.length));
			compare_field("freed_count", 32'(got.freed), 32'(want.freed));
			compare_field("live_count", 32'(got.live), 32'(want.live));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit calm;
	int stall_left = 0;
	int cycles = 0;
	int requests_sent;
	logic [TICK_W-1:0] clock_tick;
	slot_ledger ledger;

	rxst_in_if  in_ch();
	rxst_out_if out_ch();
	rxst_cfg_if cfg_ch();

	rx_slot_table_with_timeout i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_rx_slot_table_with_timeout: errors");
			$finish;
		end
	end

	// Reply side: hold ready low in random bursts.
	always @(negedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 14);
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else
			out_ch.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready)
			ledger.match_reply('{rxst_status_t'(out_ch.status), out_ch.result_slot,
				out_ch.result_length, out_ch.freed_count, out_ch.live_count});
	end

	function automatic request_t make_request(logic [OPCODE_W-1:0] op,
		logic [OWNER_W-1:0] owner, logic [SLOT_W-1:0] slot, logic [IN_LEN_W-1:0] len,
		logic [TICK_W-1:0] tick);
		request_t r;
		r.opcode = op;
		r.owner = owner;
		r.slot = slot;
		r.length = len;
		r.tick = tick;
		return r;
	endfunction

	// Mostly well-formed traffic: stores, gets aimed at held slots, frees of live owners.
	function automatic request_t pick_request();
		request_t r;
		int roll, pick, i;
		int held[$];
		roll = $urandom_range(0, 99);
		if (roll < 4)
			clock_tick = $urandom;
		else if (roll < 9)
			clock_tick = clock_tick + ledger.timeout + $urandom_range(0, 1);
		else
			clock_tick = clock_tick + $urandom_range(0, 300);
		for (i = 0; i < SLOTS_DEF; i++)
			if (ledger.owner_of[i] != 0)
				held.push_back(i);
		r.opcode = OP_STORE;
		r.owner = OWNER_W'($urandom);
		r.slot = SLOT_W'($urandom);
		r.length = IN_LEN_W'($urandom);
		r.tick = clock_tick;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				r.length = IN_LEN_W'($urandom_range(1, 2048));
			else if (pick < 16)
				r.length = IN_LEN_W'($urandom_range(2047, 2050));
			else if (pick == 19)
				r.length = '0;
		end else if (roll < 75) begin
			r.opcode = OP_GET;
			if (held.size() > 0 && $urandom_range(0, 9) < 9) begin
				r.slot = SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
				if ($urandom_range(0, 9) < 9)
					r.owner = ledger.owner_of[r.slot];
				pick = $urandom_range(0, 9);
				if (pick < 4)
					r.length = IN_LEN_W'($urandom_range(1, ledger.len_of[r.slot]));
				else if (pick < 8)
					r.length = IN_LEN_W'($urandom_range(1, 4095));
			end
		end else if (roll < 85) begin
			r.opcode = OP_FREE;
			pick = $urandom_range(0, 3);
			if (pick < 2 && held.size() > 0)
				r.owner = ledger.owner_of[held[$urandom_range(0, held.size() - 1)]];
			else if (pick == 2)
				r.owner = ledger.focus;
		end else begin
			r.opcode = OPCODE_W'($urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0)
				r.owner = '0;
			if ($urandom_range(0, 2) == 0)
				r.length = '0;
		end
		return r;
	endfunction

	task automatic drive_request(request_t r);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= r.opcode;
		in_ch.owner <= r.owner;
		in_ch.slot_index <= r.slot;
		in_ch.length <= r.length;
		in_ch.now_tick <= r.tick;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		ledger.take_request(r);
		requests_sent++;
	endtask

	// Drop valid and hold until every pending reply has arrived.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (ledger.replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(rxst_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		ledger.set_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int p, n, k;
		logic [OWNER_W-1:0] f;
		logic [TICK_W-1:0] t;
		ledger = new();
		calm = 1'b0;
		requests_sent = 0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.owner = '0;
		in_ch.slot_index = '0;
		in_ch.length = '0;
		in_ch.now_tick = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FOCUS_OWNER;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Argument errors and a no-focus store while no focus owner is set.
		drive_request(make_request(OP_STORE, 8'd3, 4'd0, 16'd100, 32'd10));
		drive_request(make_request(OP_STORE, 8'd3, 4'd0, 16'd0, 32'd10));
		drive_request(make_request(OP_GET, 8'd0, 4'd0, 16'd5, 32'd11));
		drive_request(make_request(OP_GET, 8'd7, 4'd3, 16'd0, 32'd11));
		drive_request(make_request(OP_GET, 8'd7, 4'd15, 16'd1, 32'd12));
		drive_request(make_request(OP_FREE, 8'd0, 4'd0, 16'd1, 32'd12));
		drive_request(make_request(OP_RESERVED, 8'd9, 4'd1, 16'd9, 32'd13));

		// Fill the table with the widest settings, overflow it, then free one owner.
		settle();
		write_reg(REG_FOCUS_OWNER, 32'd255);
		write_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
		for (k = 0; k < SLOTS_DEF; k++)
			drive_request(make_request(OP_STORE, 8'd0, 4'd0,
				(k == 0) ? 16'hFFFF : (k == 1) ? 16'd2049 : (k == 2) ? 16'd1 : 16'd2048,
				32'hFFFF_FFFF));
		drive_request(make_request(OP_STORE, 8'd0, 4'd0, 16'd500, 32'd0));
		drive_request(make_request(OP_FREE, 8'd255, 4'd0, 16'd0, 32'd1));

		// Zero timeout: same tick keeps a slot, one tick later it is reclaimed.
		settle();
		write_reg(REG_TIMEOUT_TICKS, 32'd0);
		drive_request(make_request(OP_STORE, 8'd0, 4'd0, 16'd64, 32'd100));
		drive_request(make_request(OP_STORE, 8'd0, 4'd0, 16'd65, 32'd100));
		drive_request(make_request(OP_STORE, 8'd0, 4'd0, 16'd66, 32'd101));
		clock_tick = 32'd101;

		for (p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: begin f = 8'd1; t = 32'd3000; end
				1: begin f = 8'd255; t = $urandom_range(1, 60); end
				2: begin f = 8'd0; t = 32'hFFFF_FFFF; end
				3: begin f = OWNER_W'($urandom_range(1, 254)); t = 32'd0; end
				4: begin f = OWNER_W'($urandom_range(1, 255)); t = $urandom; end
				5: begin f = 8'd128; t = $urandom_range(200, 5000); end
				6: begin f = OWNER_W'($urandom_range(1, 255)); t = 32'hFFFF_FFFF; end
				default: begin f = OWNER_W'($urandom_range(1, 255)); t = 32'd3000; end
			endcase
			write_reg(REG_FOCUS_OWNER, {24'd0, f});
			write_reg(REG_TIMEOUT_TICKS, t);
			calm = (p == 7);
			n = (f == 0) ? 60 : 210;
			for (k = 0; k < n; k++) begin
				if (!calm && $urandom_range(0, 99) == 0)
					settle();
				drive_request(pick_request());
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (ledger.replies_due.size() != 0)
			ledger.note_error($sformatf("%0d replies never arrived", ledger.replies_due.size()));
		$display("covered %0d requests, %0d replies: %0d stores placed (%0d aged), %0d refused full",
			requests_sent, ledger.replies_seen, ledger.stores_placed, ledger.reclaims,
			ledger.full_refusals);
		$display("%0d gets returned data, %0d slots released by owner frees",
			ledger.gets_done, ledger.owner_releases);
		if (ledger.errors == 0)
			$display("tb_rx_slot_table_with_timeout: clean");
		else
			$display("tb_rx_slot_table_with_timeout: errors");
		$finish;
	end
endmodule
